// File: hw/rtl/emrs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Energy meter reading scaler package
// Shared payload types, command codes, register indexes and scale constants.
// ----------------------------------------------------------------------------
package emrs_pkg;

  // Widths of the divider chain
  localparam int DIVD_W  = 42;      // dividend / quotient width
  localparam int DVSR_W  = 17;      // divisor and remainder width
  localparam int N_CELLS = DIVD_W;  // one quotient bit per cell

  // Command codes
  localparam logic [3:0] CMD_VOLT    = 4'd0;
  localparam logic [3:0] CMD_CURR    = 4'd1;
  localparam logic [3:0] CMD_ACTIVE  = 4'd2;
  localparam logic [3:0] CMD_ENERGY  = 4'd3;
  localparam logic [3:0] CMD_APPAR   = 4'd4;
  localparam logic [3:0] CMD_REACT   = 4'd5;
  localparam logic [3:0] CMD_PF      = 4'd6;
  localparam logic [3:0] CMD_FREQ    = 4'd7;
  localparam logic [3:0] CMD_SIGN    = 4'd8;

  // Logical channel codes
  localparam logic [1:0] LCH_ONE = 2'd1;
  localparam logic [1:0] LCH_TWO = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_CHAN_SWAP = 2'd0;
  localparam logic [1:0] CFG_I_SCALE   = 2'd1;
  localparam logic [1:0] CFG_V_SCALE   = 2'd2;

  localparam logic        RST_CHAN_SWAP = 1'b1;
  localparam logic [15:0] RST_I_SCALE   = 16'd60;
  localparam logic [15:0] RST_V_SCALE   = 16'd240;

  // Scale constants
  localparam logic [15:0]       SCALE_POWER = 16'd1540;
  localparam logic [DVSR_W-1:0] POWER_DVSR  = DVSR_W'(1540);
  localparam logic [DVSR_W-1:0] ENERGY_DVSR = DVSR_W'(1000);
  localparam logic [15:0]       PF_MULT     = 16'd1000;
  localparam logic [DVSR_W-1:0] PF_DVSR     = DVSR_W'(32768);
  localparam logic [31:0]       FREQ_NUM    = 32'd22375000;
  localparam logic [15:0]       NO_LOAD_CUT = 16'd2;

  typedef struct packed {
    logic [3:0]  command;
    logic [1:0]  channel;
    logic [31:0] raw_a;
    logic [31:0] raw_b;
    logic [31:0] raw_common;
  } emrs_in_t;

  typedef struct packed {
    logic signed [32:0] value;
    logic               channel_ok;
    logic               chip_channel;
  } emrs_out_t;

  // Per-item information that rides along the divider chain
  typedef struct packed {
    logic [DVSR_W-1:0] dvsr;
    logic              neg;    // negate the quotient
    logic              lo16;   // keep the low 16 quotient bits only
    logic              ok;
    logic              chip;
  } emrs_side_t;

  typedef struct packed {
    logic              valid;
    logic [DVSR_W-1:0] rem;
    logic [DIVD_W-1:0] work;   // dividend bits shift out, quotient bits shift in
    emrs_side_t        side;
  } emrs_cell_t;

endpackage

// File: hw/rtl/energy_meter_reading_scaler_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Energy meter reading scaler
// Turns raw metering-chip readouts into user units, one item per clock.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive in_data and raise start; the item is taken at a rising edge
//   with start high and busy low. busy is low except during reset, so a new
//   item may be offered on every cycle.
//   Output: each item gives one result, shown on out_data for one cycle with
//   out_strobe high. The receiver cannot stall; results must be taken as shown.
//   Pipeline: the result reaches the ports through one operand register
//   (loaded at the accepting edge), one multiplier register, 42 divider
//   cells (one quotient bit each) and the output register. Throughput
//   is one item per cycle, set by the cell chain handing data on every cycle.
//   Configuration: cfg_we, cfg_index and cfg_wdata write a register at the
//   edge; write only while no item is in flight.
//   Reset: synchronous, active low; empties the pipeline and restores
//   chan_swap = 1, current scale 60 and voltage scale 240.
// ----------------------------------------------------------------------------
module energy_meter_reading_scaler_top (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  emrs_pkg::emrs_in_t   in_data,
  output logic                 out_strobe,
  output emrs_pkg::emrs_out_t  out_data,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [15:0]          cfg_wdata
);
  import emrs_pkg::*;

  emrs_cell_t chain [0:N_CELLS];

  logic               in_accept;
  logic               out_strobe_r;
  emrs_out_t          out_data_r;
  logic [32:0]        mag33;
  logic signed [32:0] value_nxt;

  assign busy      = ~rst_n;
  assign in_accept = start & ~busy;

  emrs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_accept (in_accept),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cell_in   (chain[0])
  );

  for (genvar i = 0; i < N_CELLS; i++) begin : g_cell
    emrs_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .d_in  (chain[i]),
      .d_out (chain[i+1])
    );
  end

  always_comb begin
    mag33 = chain[N_CELLS].side.lo16 ? {17'd0, chain[N_CELLS].work[15:0]}
                                     : chain[N_CELLS].work[32:0];
    value_nxt = chain[N_CELLS].side.neg ? -$signed(mag33) : $signed(mag33);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= chain[N_CELLS].valid;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r.value        <= value_nxt;
    out_data_r.channel_ok   <= chain[N_CELLS].side.ok;
    out_data_r.chip_channel <= chain[N_CELLS].side.chip;
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

  a_chain_fed_by_accept: assert property (@(posedge clk) disable iff (!rst_n)
    chain[0].valid |-> $past(in_accept, 2))
    else $error("chain entry valid without an accepted item");

  a_strobe_follows_chain: assert property (@(posedge clk) disable iff (!rst_n)
    chain[N_CELLS].valid |=> out_strobe_r)
    else $error("finished item dropped at the output");

  a_strobe_has_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |-> $past(chain[N_CELLS].valid))
    else $error("result strobe without a finished item");

endmodule

// File: hw/rtl/emrs_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Divider cell
// One restoring-division step: brings in the next dividend bit, subtracts the
// divisor when it fits and shifts the quotient bit in. Registered output.
// ----------------------------------------------------------------------------
module emrs_cell (
  input  logic                  clk,
  input  logic                  rst_n,
  input  emrs_pkg::emrs_cell_t  d_in,
  output emrs_pkg::emrs_cell_t  d_out
);
  import emrs_pkg::*;

  logic                valid_r;
  logic [DVSR_W-1:0]   rem_r;
  logic [DIVD_W-1:0]   work_r;
  emrs_side_t          side_r;

  logic [DVSR_W:0]     trial;
  logic                fits;
  logic [DVSR_W-1:0]   rem_nxt;
  logic [DIVD_W-1:0]   work_nxt;

  always_comb begin
    trial    = {d_in.rem, d_in.work[DIVD_W-1]};
    fits     = (trial >= {1'b0, d_in.side.dvsr});
    rem_nxt  = fits ? DVSR_W'(trial - {1'b0, d_in.side.dvsr}) : DVSR_W'(trial);
    work_nxt = {d_in.work[DIVD_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= d_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    work_r <= work_nxt;
    side_r <= d_in.side;
  end

  assign d_out.valid = valid_r;
  assign d_out.rem   = rem_r;
  assign d_out.work  = work_r;
  assign d_out.side  = side_r;

  a_rem_below_dvsr: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> (rem_r < side_r.dvsr))
    else $error("divider cell remainder not below divisor");

endmodule

// File: hw/rtl/emrs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Front end
// Holds the configuration registers, maps the channel, picks multiplier and
// divisor operands per command, multiplies and forms the chain's dividend.
// ----------------------------------------------------------------------------
module emrs_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_accept,
  input  emrs_pkg::emrs_in_t    in_data,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [15:0]           cfg_wdata,
  output emrs_pkg::emrs_cell_t  cell_in
);
  import emrs_pkg::*;

  typedef enum logic [1:0] {
    MODE_FULL,    // whole product is the dividend
    MODE_HI,      // product bits 31:16
    MODE_HI_CUT   // product bits 31:16, zero below the no-load cutoff
  } mode_t;

  logic        chan_swap_r;
  logic [15:0] i_scale_r;
  logic [15:0] v_scale_r;

  // operand stage
  logic        s1_valid_r;
  logic [31:0] s1_a_r, a_nxt;
  logic [15:0] s1_b_r, b_nxt;
  mode_t       s1_mode_r, mode_nxt;
  emrs_side_t  s1_side_r, side_nxt;

  // product stage
  logic        s2_valid_r;
  logic [47:0] s2_prod_r, prod_nxt;
  mode_t       s2_mode_r;
  emrs_side_t  s2_side_r;

  logic        ch_valid;
  logic        chip;
  logic [31:0] raw;
  logic [31:0] mag;
  logic [15:0] pf_raw;
  logic [15:0] pf_mag;
  logic [15:0] hi;
  logic [DIVD_W-1:0] divd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_swap_r <= RST_CHAN_SWAP;
      i_scale_r   <= RST_I_SCALE;
      v_scale_r   <= RST_V_SCALE;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CHAN_SWAP: chan_swap_r <= cfg_wdata[0];
        CFG_I_SCALE:   i_scale_r   <= cfg_wdata;
        CFG_V_SCALE:   v_scale_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    ch_valid = (in_data.channel == LCH_ONE) || (in_data.channel == LCH_TWO);
    chip     = ch_valid & ((in_data.channel == LCH_TWO) ^ chan_swap_r);
    raw      = chip ? in_data.raw_b : in_data.raw_a;
    mag      = raw[31] ? (~raw + 32'd1) : raw;
    pf_raw   = raw[15:0];
    pf_mag   = pf_raw[15] ? (~pf_raw + 16'd1) : pf_raw;

    // default: zero result, flagged bad
    a_nxt         = '0;
    b_nxt         = 16'd1;
    mode_nxt      = MODE_FULL;
    side_nxt.dvsr = DVSR_W'(1);
    side_nxt.neg  = 1'b0;
    side_nxt.lo16 = 1'b0;
    side_nxt.ok   = 1'b0;
    side_nxt.chip = 1'b0;

    case (in_data.command)
      CMD_VOLT: begin
        a_nxt       = in_data.raw_common;
        b_nxt       = v_scale_r;
        mode_nxt    = MODE_HI;
        side_nxt.ok = 1'b1;
      end
      CMD_FREQ: begin
        a_nxt         = FREQ_NUM;
        side_nxt.dvsr = {1'b0, in_data.raw_common[15:0]} + DVSR_W'(1);
        side_nxt.lo16 = 1'b1;
        side_nxt.ok   = 1'b1;
      end
      CMD_SIGN: begin
        a_nxt         = 32'd1;
        side_nxt.ok   = ch_valid;
        side_nxt.chip = chip;
        side_nxt.neg  = ch_valid &
                        (chip ? in_data.raw_common[11] : in_data.raw_common[10]);
      end
      CMD_CURR: begin
        side_nxt.ok   = ch_valid;
        side_nxt.chip = chip;
        if (ch_valid) begin
          a_nxt    = raw;
          b_nxt    = i_scale_r;
          mode_nxt = MODE_HI_CUT;
        end
      end
      CMD_ACTIVE, CMD_APPAR, CMD_REACT: begin
        side_nxt.ok   = ch_valid;
        side_nxt.chip = chip;
        if (ch_valid) begin
          a_nxt         = mag;
          side_nxt.dvsr = POWER_DVSR;
        end
      end
      CMD_ENERGY: begin
        side_nxt.ok   = ch_valid;
        side_nxt.chip = chip;
        if (ch_valid) begin
          a_nxt         = mag;
          b_nxt         = SCALE_POWER;
          side_nxt.dvsr = ENERGY_DVSR;
        end
      end
      CMD_PF: begin
        side_nxt.ok   = ch_valid;
        side_nxt.chip = chip;
        if (ch_valid) begin
          // divide the magnitude, then restore the sign: truncates toward zero
          a_nxt         = {16'd0, pf_mag};
          b_nxt         = PF_MULT;
          side_nxt.dvsr = PF_DVSR;
          side_nxt.neg  = pf_raw[15];
        end
      end
      default: ;
    endcase
  end

  assign prod_nxt = s1_a_r * s1_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_accept;
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_a_r    <= a_nxt;
    s1_b_r    <= b_nxt;
    s1_mode_r <= mode_nxt;
    s1_side_r <= side_nxt;
    s2_prod_r <= prod_nxt;
    s2_mode_r <= s1_mode_r;
    s2_side_r <= s1_side_r;
  end

  always_comb begin
    hi = s2_prod_r[31:16];
    case (s2_mode_r)
      MODE_FULL:   divd = s2_prod_r[DIVD_W-1:0];
      MODE_HI:     divd = DIVD_W'(hi);
      MODE_HI_CUT: divd = (hi < NO_LOAD_CUT) ? '0 : DIVD_W'(hi);
      default:     divd = '0;
    endcase
  end

  assign cell_in.valid = s2_valid_r;
  assign cell_in.rem   = '0;
  assign cell_in.work  = divd;
  assign cell_in.side  = s2_side_r;

endmodule
